/* design/rstats_pkg.sv */
// ----------------------------------------------------------------------------
// rstats_pkg
// Shared types and constants for the ride-session statistics block.
// ----------------------------------------------------------------------------
package rstats_pkg;

  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned DIVIDEND_W = 44;
  localparam int unsigned STEP_CNT_W = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] AVG_MAX = {QUOT_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_PAUSE  = 3'd1,
    CMD_RESUME = 3'd2,
    CMD_FINISH = 3'd3,
    CMD_UPDATE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_ENDED   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STOP,
    ST_DRIVE,
    ST_DIV_MOV,
    ST_WAIT_MOV,
    ST_DIV_ALL,
    ST_WAIT_ALL,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [15:0] speed_in;
    logic [31:0] distance_cm;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  session_status;
    logic [31:0] drive_time_ms;
    logic [15:0] max_speed;
    logic [15:0] avg_moving;
    logic [15:0] avg_overall;
  } res_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* design/rstats_if.sv */
// ----------------------------------------------------------------------------
// rstats_if
// Valid/ready channels for commands and for result items.
// ----------------------------------------------------------------------------
interface rstats_cmd_if;
  import rstats_pkg::*;

  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rstats_res_if;
  import rstats_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rstats_div.sv */
// ----------------------------------------------------------------------------
// rstats_div
// Bit-serial restoring divider, one quotient bit per cycle, saturating the
// quotient at its full width.
// ----------------------------------------------------------------------------
module rstats_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [rstats_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [rstats_pkg::DIVISOR_W-1:0]     divisor,
  output rstats_pkg::div_status_t              stat,
  output logic [rstats_pkg::QUOT_W-1:0]        quotient
);
  import rstats_pkg::*;

  localparam int unsigned HI_W = DIVIDEND_W - QUOT_W;

  logic                  busy;
  logic                  done;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [QUOT_W-1:0]     shreg;
  logic [STEP_CNT_W-1:0] cnt;

  logic [HI_W-1:0]       hi_part;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  assign hi_part = dividend[DIVIDEND_W-1:QUOT_W];
  assign trial   = {rem, shreg[QUOT_W-1]};
  assign diff    = {1'b0, trial} - {2'b00, dsr};
  assign ge      = ~diff[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dsr <= divisor;
        // quotient overflows when the upper part alone reaches the divisor
        if ({{(DIVISOR_W-HI_W){1'b0}}, hi_part} >= divisor) begin
          shreg <= AVG_MAX;
          done  <= 1'b1;
        end else begin
          rem   <= {{(DIVISOR_W-HI_W){1'b0}}, hi_part};
          shreg <= dividend[QUOT_W-1:0];
          cnt   <= STEP_CNT_W'(QUOT_W - 1);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        shreg <= {shreg[QUOT_W-2:0], ge};
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = shreg;

endmodule

/* design/ride_session_trip_stats_top.sv */
// Start, pause, resume, finish and ignored commands go from ST_IDLE to ST_DONE
// and then to the output register; an update first passes ST_STOP, ST_DRIVE and
// the shared bit-serial divider, which runs 16 steps for the moving average and
// 16 more for the overall average unless a quotient saturates or its divisor is 0.
// Throughput: one item at a time; the next command is taken once the result
// sits in the output register. Reset (rst, synchronous) clears all session state.
// ----------------------------------------------------------------------------
// ride_session_trip_stats_top
// Ride-session keeper: session mode, drive time, peak speed and averages.
// ----------------------------------------------------------------------------
module ride_session_trip_stats_top (
  input  logic         clk,
  input  logic         rst,
  rstats_cmd_if.sink   cmd_in,
  rstats_res_if.source res_out
);
  import rstats_pkg::*;

  seq_state_t state, state_next;

  mode_t       mode;
  logic [31:0] start_stamp;
  logic [31:0] pause_stamp;
  logic [31:0] stopped_total;
  logic [31:0] drive_total;
  logic [15:0] peak_speed;
  logic [15:0] moving_average;
  logic [15:0] overall_average;

  logic [31:0] elapsed;
  logic [31:0] gap;
  logic [31:0] stop_sum;
  logic [31:0] dist_r;
  logic [15:0] spd_r;
  logic [35:0] prod15;
  logic [39:0] prod225;

  logic        res_valid;
  res_item_t   res_q;

  logic        cmd_fire;
  logic        upd_live;
  logic        div_start;
  logic [DIVISOR_W-1:0] div_divisor;
  div_status_t div_stat;
  logic [QUOT_W-1:0]    div_quot;

  assign cmd_fire = cmd_in.valid && cmd_in.ready;
  assign upd_live = (cmd_in.data.command == CMD_UPDATE) &&
                    (mode inside {MODE_RUNNING, MODE_PAUSED});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd_in.ready = 1'b0;
    div_start    = 1'b0;
    div_divisor  = elapsed;
    case (state)
      ST_IDLE: begin
        cmd_in.ready = 1'b1;
        if (cmd_in.valid) begin
          state_next = upd_live ? ST_STOP : ST_DONE;
        end
      end
      ST_STOP:  state_next = ST_DRIVE;
      ST_DRIVE: state_next = ST_DIV_MOV;
      ST_DIV_MOV: begin
        div_divisor = drive_total;
        if (drive_total != '0) begin
          div_start  = 1'b1;
          state_next = ST_WAIT_MOV;
        end else begin
          state_next = ST_DIV_ALL;
        end
      end
      ST_WAIT_MOV: begin
        if (div_stat.done) begin
          state_next = ST_DIV_ALL;
        end
      end
      ST_DIV_ALL: begin
        if (elapsed != '0) begin
          div_start  = 1'b1;
          state_next = ST_WAIT_ALL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WAIT_ALL: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || res_out.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // session state and update datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      start_stamp     <= '0;
      pause_stamp     <= '0;
      stopped_total   <= '0;
      drive_total     <= '0;
      peak_speed      <= '0;
      moving_average  <= '0;
      overall_average <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            dist_r <= cmd_in.data.distance_cm;
            spd_r  <= cmd_in.data.speed_in;
            case (cmd_in.data.command)
              CMD_START: begin
                if (mode == MODE_IDLE) begin
                  stopped_total   <= '0;
                  drive_total     <= '0;
                  peak_speed      <= '0;
                  moving_average  <= '0;
                  overall_average <= '0;
                  start_stamp     <= cmd_in.data.now_ms;
                  pause_stamp     <= cmd_in.data.now_ms;
                  mode            <= MODE_PAUSED;
                end
              end
              CMD_PAUSE: begin
                if (mode == MODE_RUNNING) begin
                  pause_stamp <= cmd_in.data.now_ms;
                  mode        <= MODE_PAUSED;
                end
              end
              CMD_RESUME: begin
                if (mode == MODE_PAUSED) begin
                  stopped_total <= stopped_total + (cmd_in.data.now_ms - pause_stamp);
                  mode          <= MODE_RUNNING;
                end
              end
              CMD_FINISH: begin
                if (mode == MODE_RUNNING) begin
                  pause_stamp <= cmd_in.data.now_ms;
                end
                mode <= MODE_ENDED;
              end
              CMD_UPDATE: begin
                elapsed <= cmd_in.data.now_ms - start_stamp;
                gap     <= (mode == MODE_PAUSED) ? (cmd_in.data.now_ms - pause_stamp) : '0;
              end
              default: ;
            endcase
          end
        end
        ST_STOP: begin
          stop_sum <= stopped_total + gap;
          prod15   <= {dist_r, 4'b0000} - {4'b0000, dist_r};
        end
        ST_DRIVE: begin
          drive_total <= (elapsed > stop_sum) ? (elapsed - stop_sum) : '0;
          if (spd_r > peak_speed) begin
            peak_speed <= spd_r;
          end
          // 3600 = 15 * 15 * 16
          prod225 <= {prod15, 4'b0000} - {4'b0000, prod15};
        end
        ST_WAIT_MOV: begin
          if (div_stat.done) begin
            moving_average <= div_quot;
          end
        end
        ST_WAIT_ALL: begin
          if (div_stat.done) begin
            overall_average <= div_quot;
          end
        end
        default: ;
      endcase
    end
  end

  rstats_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({prod225, 4'b0000}),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_out.ready) begin
        res_valid <= 1'b0;
      end
      if (state == ST_DONE && (!res_valid || res_out.ready)) begin
        res_valid <= 1'b1;
        res_q.session_status <= mode;
        res_q.drive_time_ms  <= drive_total;
        res_q.max_speed      <= peak_speed;
        res_q.avg_moving     <= moving_average;
        res_q.avg_overall    <= overall_average;
      end
    end
  end

  assign res_out.valid = res_valid;
  assign res_out.data  = res_q;

`ifndef SYNTHESIS
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_WAIT_MOV || state == ST_WAIT_ALL))
    else $error("divider result with nobody waiting");

  a_transfer_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> state != ST_IDLE)
    else $error("command transfer did not start processing");

  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRIVE |=> drive_total <= elapsed)
    else $error("drive time exceeds elapsed time");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_valid && !res_out.ready) |=> state == ST_DONE)
    else $error("result overwritten before transfer");
`endif

endmodule

/* test/ride_session_trip_stats_top_tb.sv */
// ----------------------------------------------------------------------------
// ride_session_trip_stats_top_tb
// Drives session commands through the valid/ready channels under random
// stalls. A scoreboard predicts each result item and checks every field.
// ----------------------------------------------------------------------------
module ride_session_trip_stats_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rstats_pkg::*;

  localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] CMD_RESERVED_MID   = 3'd6;
  localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
  localparam int unsigned SESSION_ITEMS = 1900;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 60;

  // tracks the session and queues the result that each command must give
  class session_scoreboard;
    mode_t       mode;
    logic [31:0] start_stamp;
    logic [31:0] pause_stamp;
    logic [31:0] stopped_ms;
    logic [31:0] drive_ms;
    logic [15:0] peak_speed;
    logic [15:0] moving_avg;
    logic [15:0] overall_avg;
    res_item_t   pending[$];
    int          errors;

    function new();
      mode        = MODE_IDLE;
      start_stamp = '0;
      pause_stamp = '0;
      stopped_ms  = '0;
      drive_ms    = '0;
      peak_speed  = '0;
      moving_avg  = '0;
      overall_avg = '0;
      errors      = 0;
    endfunction

    function logic [15:0] speed_over(logic [31:0] dist_cm, logic [31:0] span_ms);
      logic [63:0] q;
      q = ({32'd0, dist_cm} * 64'd3600) / {32'd0, span_ms};
      return (q > {48'd0, AVG_MAX}) ? AVG_MAX : q[15:0];
    endfunction

    // returns 1 when the command changes the session
    function bit note_command(cmd_item_t c);
      logic [31:0] elapsed;
      logic [31:0] stop;
      res_item_t   r;
      bit          acted;
      acted = 1'b0;
      case (c.command)
        CMD_START: if (mode == MODE_IDLE) begin
          stopped_ms  = '0;
          drive_ms    = '0;
          peak_speed  = '0;
          moving_avg  = '0;
          overall_avg = '0;
          start_stamp = c.now_ms;
          pause_stamp = c.now_ms;
          mode        = MODE_PAUSED;
          acted       = 1'b1;
        end
        CMD_PAUSE: if (mode == MODE_RUNNING) begin
          pause_stamp = c.now_ms;
          mode        = MODE_PAUSED;
          acted       = 1'b1;
        end
        CMD_RESUME: if (mode == MODE_PAUSED) begin
          stopped_ms = stopped_ms + (c.now_ms - pause_stamp);
          mode       = MODE_RUNNING;
          acted      = 1'b1;
        end
        CMD_FINISH: begin
          if (mode == MODE_RUNNING) pause_stamp = c.now_ms;
          acted = (mode != MODE_ENDED);
          mode  = MODE_ENDED;
        end
        CMD_UPDATE: if (mode == MODE_RUNNING || mode == MODE_PAUSED) begin
          elapsed = c.now_ms - start_stamp;
          stop    = stopped_ms;
          // an open pause counts as stopped time
          if (mode == MODE_PAUSED) stop = stop + (c.now_ms - pause_stamp);
          drive_ms = (elapsed > stop) ? elapsed - stop : '0;
          if (c.speed_in > peak_speed) peak_speed = c.speed_in;
          if (drive_ms != 0) moving_avg = speed_over(c.distance_cm, drive_ms);
          if (elapsed != 0) overall_avg = speed_over(c.distance_cm, elapsed);
          acted = 1'b1;
        end
        default: ;
      endcase
      r.session_status = mode;
      r.drive_time_ms  = drive_ms;
      r.max_speed      = peak_speed;
      r.avg_moving     = moving_avg;
      r.avg_overall    = overall_avg;
      pending.push_back(r);
      return acted;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      // keep the log short if the block is badly broken
      if (errors < 100) $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(res_item_t got);
      res_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", got.drive_time_ms, '0);
        return;
      end
      want = pending.pop_front();
      if (got.session_status !== want.session_status)
        report_mismatch("session_status", 32'(got.session_status),
                        32'(want.session_status));
      if (got.drive_time_ms !== want.drive_time_ms)
        report_mismatch("drive_time_ms", got.drive_time_ms, want.drive_time_ms);
      if (got.max_speed !== want.max_speed)
        report_mismatch("max_speed", 32'(got.max_speed), 32'(want.max_speed));
      if (got.avg_moving !== want.avg_moving)
        report_mismatch("avg_moving", 32'(got.avg_moving), 32'(want.avg_moving));
      if (got.avg_overall !== want.avg_overall)
        report_mismatch("avg_overall", 32'(got.avg_overall), 32'(want.avg_overall));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rstats_cmd_if cmd_ch ();
  rstats_res_if res_ch ();

  ride_session_trip_stats_top dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_ch),
    .res_out (res_ch)
  );

  session_scoreboard sb = new();

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_start = 1'b0;
  int sent_total = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  function automatic cmd_item_t make_cmd(logic [2:0] code, logic [31:0] now,
                                         logic [15:0] spd, logic [31:0] dist_cm);
    cmd_item_t c;
    c.command     = code;
    c.now_ms      = now;
    c.speed_in    = spd;
    c.distance_cm = dist_cm;
    return c;
  endfunction

  task automatic send_command(input cmd_item_t c);
    while (tx_idle && $urandom_range(0, 99) < 29) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    void'(sb.note_command(c));
    sent_total++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !(rx_idle && $urandom_range(0, 99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] t0;
    logic [31:0] t;
    logic [31:0] when;
    logic [31:0] spd;
    logic [31:0] dist_cm;
    logic [2:0]  code;
    int          pick;
    bit          held;
    bit          drained;

    held    = 1'b0;
    drained = 1'b0;
    t0      = 32'hFFFF_F000;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // commands before any session, and reserved codes
    send_command(make_cmd(CMD_UPDATE, 32'h1234_5678, 16'hFFFF, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_PAUSE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_RESUME, 32'h0, 16'h0, 32'h0));
    send_command(make_cmd(CMD_RESERVED_FIRST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_RESERVED_MID, 32'h0, 16'h0, 32'h0));
    send_command(make_cmd(CMD_RESERVED_LAST, 32'hA5A5_5A5A, 16'h5A5A, 32'h5A5A_A5A5));
    // session opens just below the timestamp wrap
    send_command(make_cmd(CMD_START, t0, 16'h0, 32'h0));
    send_command(make_cmd(CMD_START, t0 + 5, 16'h0, 32'h0));
    send_command(make_cmd(CMD_PAUSE, t0 + 10, 16'h0, 32'h0));
    // no time elapsed: both averages hold
    send_command(make_cmd(CMD_UPDATE, t0, 16'd1234, 32'd5000));
    // paused since start: zero drive time, overall average saturates
    send_command(make_cmd(CMD_UPDATE, t0 + 500, 16'h0, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_RESUME, t0 + 1000, 16'h0, 32'h0));
    send_command(make_cmd(CMD_UPDATE, t0 + 5000, 16'hFFFF, 32'd1000));
    send_command(make_cmd(CMD_RESUME, t0 + 5100, 16'h0, 32'h0));
    send_command(make_cmd(CMD_UPDATE, t0 + 5200, 16'd7, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_PAUSE, t0 + 6000, 16'h0, 32'h0));
    send_command(make_cmd(CMD_UPDATE, t0 + 7000, 16'd0, 32'd0));
    send_command(make_cmd(CMD_RESUME, t0 + 9000, 16'h0, 32'h0));
    send_command(make_cmd(CMD_UPDATE, t0 + 32'h2000, 16'd300, 32'd50000));
    // stamp earlier than the stopped time: drive time clamps to zero
    send_command(make_cmd(CMD_UPDATE, t0 + 100, 16'd300, 32'd50000));

    t = t0 + 32'h3000;
    while (sent_total < SESSION_ITEMS) begin
      // a stretch with no stalls on either side
      tx_idle = !(sent_total >= 1200 && sent_total < 1500);
      rx_idle = tx_idle;
      if (!held && sent_total >= 500) begin
        held       = 1'b1;
        hold_start = 1'b1;
      end
      if (!drained && sent_total >= 1000) begin
        drained = 1'b1;
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end

      case ($urandom_range(0, 9))
        0:       t = t;
        1, 2, 3, 4, 5, 6: t = t + $urandom_range(1, 2000);
        7, 8:    t = t + $urandom_range(2000, 200000);
        default: t = t + $urandom;
      endcase
      spd     = $urandom >> $urandom_range(0, 16);
      dist_cm = $urandom >> $urandom_range(0, 31);
      when    = t;
      pick    = $urandom_range(0, 99);
      if (pick < 55)
        code = CMD_UPDATE;
      else if (pick < 85)
        code = (sb.mode == MODE_RUNNING) ? CMD_PAUSE : CMD_RESUME;
      else if (pick < 90)
        code = (sb.mode == MODE_RUNNING) ? CMD_RESUME : CMD_PAUSE;
      else if (pick < 93)
        code = CMD_START;
      else if (pick < 96)
        code = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
      else begin
        // stray stamp anywhere in the range
        code = CMD_UPDATE;
        when = $urandom;
      end
      send_command(make_cmd(code, when, spd[15:0], dist_cm));
    end

    // close the session from running, then poke the ended state
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    if (sb.mode == MODE_PAUSED) send_command(make_cmd(CMD_RESUME, t + 10, 16'h0, 32'h0));
    send_command(make_cmd(CMD_FINISH, t + 20, 16'h0, 32'h0));
    send_command(make_cmd(CMD_UPDATE, t + 30, 16'hFFFF, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_START, t + 40, 16'h0, 32'h0));
    send_command(make_cmd(CMD_FINISH, t + 50, 16'h0, 32'h0));
    cmd_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
